// File: hw/rtl/monotone_boolean_chain_learner_top_assert.svh
// ----------------------------------------------------------------------------
// monotone boolean chain learner assertion macros
// shared concurrent assertion forms, clocked on clock and gated by reset
// ----------------------------------------------------------------------------
`ifndef MONOTONE_BOOLEAN_CHAIN_LEARNER_TOP_ASSERT_SVH
`define MONOTONE_BOOLEAN_CHAIN_LEARNER_TOP_ASSERT_SVH

// same-cycle implication
`define MBCL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBCL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mbcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcl_pkg
// shared types, command codes and the hansel chain query order table
// ----------------------------------------------------------------------------
package mbcl_pkg;

   localparam int DIMS     = 6;
   localparam int NV       = 1 << DIMS;
   localparam int CMD_W    = 2;
   localparam int VECTOR_W = 6;

   typedef logic [DIMS-1:0]     vec_type;
   typedef logic [VECTOR_W-1:0] field_vec_type;
   typedef vec_type [NV-1:0]    ask_order_type;
   typedef int                  chain_arr_type [NV+2];

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_NEXT   = 2'd1,
      CMD_ANSWER = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_APPLY   = 4'b0010,
      ST_SWEEP   = 4'b0100,
      ST_DELIVER = 4'b1000
   } ctrl_state_type;

   // travels down the cell row, one cell per clock
   typedef struct packed {
      logic    active;
      logic    found;
      vec_type vector;
      logic    known;
      logic    value;
      logic    all_known;
   } probe_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic    clear;
      logic    apply;
      logic    answer;
      vec_type pending_vector;
      logic    find_unknown;
      logic    match_read;
      vec_type read_vector;
   } cell_ctrl_type;

   function automatic logic chain_less(chain_arr_type el, chain_arr_type st,
                                       chain_arr_type ln, int a, int b);
      logic result;
      logic decided;
      int   i;
      result  = 1'b0;
      decided = 1'b0;
      if (ln[a] != ln[b]) begin
         result  = (ln[a] < ln[b]);
         decided = 1'b1;
      end
      for (i = 0; i < NV; i++) begin
         if (!decided && (i < ln[a])) begin
            if (el[st[a] + i] != el[st[b] + i]) begin
               result  = (el[st[a] + i] < el[st[b] + i]);
               decided = 1'b1;
            end
         end
      end
      return result;
   endfunction

   // recursive chain construction, then sort by length and elements
   function automatic ask_order_type build_ask_order();
      chain_arr_type ce;
      chain_arr_type cs;
      chain_arr_type cl;
      chain_arr_type ne;
      chain_arr_type ns;
      chain_arr_type nl;
      chain_arr_type idx;
      ask_order_type order;
      int            nc;
      int            nn;
      int            pos;
      int            bit_val;
      int            i;
      int            k;
      int            m;
      int            j;
      int            v;
      int            n;
      logic          done;
      order = '0;
      for (i = 0; i < NV + 2; i++) begin
         ce[i]  = 0;
         cs[i]  = 0;
         cl[i]  = 0;
         ne[i]  = 0;
         ns[i]  = 0;
         nl[i]  = 0;
         idx[i] = 0;
      end
      ce[0] = 0;
      ce[1] = 1;
      cs[0] = 0;
      cl[0] = 2;
      nc    = 1;
      for (i = 1; i < DIMS; i++) begin
         bit_val = 1 << i;
         nn      = 0;
         pos     = 0;
         for (k = 0; k < nc; k++) begin
            ns[nn] = pos;
            for (m = 0; m < cl[k]; m++) begin
               ne[pos] = ce[cs[k] + m];
               pos++;
            end
            ne[pos] = ce[cs[k] + cl[k] - 1] | bit_val;
            pos++;
            nl[nn] = cl[k] + 1;
            nn++;
         end
         for (k = 0; k < nc; k++) begin
            if (cl[k] >= 2) begin
               ns[nn] = pos;
               for (m = 0; m < cl[k] - 1; m++) begin
                  ne[pos] = ce[cs[k] + m] | bit_val;
                  pos++;
               end
               nl[nn] = cl[k] - 1;
               nn++;
            end
         end
         ce = ne;
         cs = ns;
         cl = nl;
         nc = nn;
      end
      for (k = 0; k < nc; k++) begin
         v    = k;
         j    = k;
         done = 1'b0;
         while (!done) begin
            if ((j > 0) && chain_less(ce, cs, cl, v, idx[j - 1])) begin
               idx[j] = idx[j - 1];
               j--;
            end else begin
               done = 1'b1;
            end
         end
         idx[j] = v;
      end
      n = 0;
      for (k = 0; k < nc; k++) begin
         for (m = 0; m < cl[idx[k]]; m++) begin
            if (n < NV) begin
               order[n] = vec_type'(ce[cs[idx[k]] + m]);
               n++;
            end
         end
      end
      return order;
   endfunction

   localparam ask_order_type ASK_ORDER = build_ask_order();

endpackage

// File: hw/rtl/mbcl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcl_cell
// one vector of the cube: known and value bits, monotone update, probe stage
// ----------------------------------------------------------------------------
`include "monotone_boolean_chain_learner_top_assert.svh"

module mbcl_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  mbcl_pkg::vec_type       cell_vector,
   input  mbcl_pkg::cell_ctrl_type cell_ctrl,
   input  mbcl_pkg::probe_type     prev_probe,
   output mbcl_pkg::probe_type     next_probe
);

   logic                known_ff;
   logic                value_ff;
   logic                covered;
   logic                match;
   mbcl_pkg::probe_type probe_ff;
   mbcl_pkg::probe_type probe_in;

   // above the pending vector for a true answer, below it for a false one
   assign covered = cell_ctrl.answer
                    ? ((cell_ctrl.pending_vector & ~cell_vector) == '0)
                    : ((cell_vector & ~cell_ctrl.pending_vector) == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= 1'b0;
         value_ff <= 1'b0;
      end else if (cell_ctrl.clear) begin
         known_ff <= 1'b0;
         value_ff <= 1'b0;
      end else if (cell_ctrl.apply && covered) begin
         known_ff <= 1'b1;
         value_ff <= cell_ctrl.answer;
      end
   end

   assign match = (cell_ctrl.find_unknown && !known_ff) ||
                  (cell_ctrl.match_read && (cell_vector == cell_ctrl.read_vector));

   always_comb begin
      probe_in           = prev_probe;
      probe_in.all_known = prev_probe.all_known & known_ff;
      if (prev_probe.active && !prev_probe.found && match) begin
         probe_in.found  = 1'b1;
         probe_in.vector = cell_vector;
         probe_in.known  = known_ff;
         probe_in.value  = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign next_probe = probe_ff;

   `MBCL_ASSERT_NEXT(a_answer_marks_pending,
      cell_ctrl.apply && (cell_ctrl.pending_vector == cell_vector),
      known_ff && (value_ff == $past(cell_ctrl.answer)),
      "answered vector not settled to the answer")
   `MBCL_ASSERT_NOW(a_no_update_mid_sweep,
      prev_probe.active,
      !cell_ctrl.apply && !cell_ctrl.clear,
      "cell state changed while a probe is in flight")
   `MBCL_ASSERT_NEXT(a_clear_forgets,
      cell_ctrl.clear,
      !known_ff && !value_ff,
      "cell still settled after a clear")

endmodule

// File: hw/rtl/mbcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcl_ctrl
// command sequencer: word intake, cell broadcast, probe launch and result
// ----------------------------------------------------------------------------
`include "monotone_boolean_chain_learner_top_assert.svh"

module mbcl_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mbcl_pkg::CMD_W-1:0]    req_command,
   input  logic                          req_answer_bit,
   input  logic [mbcl_pkg::VECTOR_W-1:0] req_read_vector,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mbcl_pkg::VECTOR_W-1:0] rsp_query_vector,
   output logic                          rsp_query_valid,
   output logic                          rsp_all_resolved,
   output logic                          rsp_vector_known,
   output logic                          rsp_vector_value,
   output mbcl_pkg::cell_ctrl_type       cell_ctrl,
   output mbcl_pkg::probe_type           head_probe,
   input  mbcl_pkg::probe_type           tail_probe
);

   mbcl_pkg::ctrl_state_type state_ff;
   mbcl_pkg::ctrl_state_type state_in;
   mbcl_pkg::cmd_type        cmd_ff;
   logic                     answer_ff;
   mbcl_pkg::vec_type        read_vector_ff;
   logic                     pending_valid_ff;
   mbcl_pkg::vec_type        pending_vector_ff;
   logic                     launch_ff;
   logic                     req_accept;
   logic                     rsp_free;
   logic                     capture;
   mbcl_pkg::field_vec_type  res_query_vector_ff;
   logic                     res_query_valid_ff;
   logic                     res_all_resolved_ff;
   logic                     res_vector_known_ff;
   logic                     res_vector_value_ff;
   logic                     rsp_valid_ff;
   mbcl_pkg::field_vec_type  rsp_query_vector_ff;
   logic                     rsp_query_valid_ff;
   logic                     rsp_all_resolved_ff;
   logic                     rsp_vector_known_ff;
   logic                     rsp_vector_value_ff;

   assign req_stall  = (state_ff != mbcl_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign capture    = (state_ff == mbcl_pkg::ST_SWEEP) && tail_probe.active;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbcl_pkg::ST_IDLE: begin
            if (req_accept) state_in = mbcl_pkg::ST_APPLY;
         end
         mbcl_pkg::ST_APPLY: begin
            state_in = mbcl_pkg::ST_SWEEP;
         end
         mbcl_pkg::ST_SWEEP: begin
            if (tail_probe.active) state_in = mbcl_pkg::ST_DELIVER;
         end
         mbcl_pkg::ST_DELIVER: begin
            if (rsp_free) state_in = mbcl_pkg::ST_IDLE;
         end
         default: begin
            state_in = mbcl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mbcl_pkg::ST_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= (state_ff == mbcl_pkg::ST_APPLY);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff         <= mbcl_pkg::cmd_type'(req_command);
         answer_ff      <= req_answer_bit;
         read_vector_ff <= mbcl_pkg::vec_type'(req_read_vector);
      end
   end

   // pending query
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff  <= 1'b0;
         pending_vector_ff <= '0;
      end else if (state_ff == mbcl_pkg::ST_APPLY) begin
         if ((cmd_ff == mbcl_pkg::CMD_CLEAR) || (cmd_ff == mbcl_pkg::CMD_ANSWER)) begin
            pending_valid_ff <= 1'b0;
         end
      end else if (capture && (cmd_ff == mbcl_pkg::CMD_NEXT)) begin
         pending_valid_ff <= tail_probe.found;
         if (tail_probe.found) pending_vector_ff <= tail_probe.vector;
      end
   end

   always_comb begin
      cell_ctrl.clear          = (state_ff == mbcl_pkg::ST_APPLY) &&
                                 (cmd_ff == mbcl_pkg::CMD_CLEAR);
      cell_ctrl.apply          = (state_ff == mbcl_pkg::ST_APPLY) &&
                                 (cmd_ff == mbcl_pkg::CMD_ANSWER) && pending_valid_ff;
      cell_ctrl.answer         = answer_ff;
      cell_ctrl.pending_vector = pending_vector_ff;
      cell_ctrl.find_unknown   = (cmd_ff == mbcl_pkg::CMD_NEXT);
      cell_ctrl.match_read     = (cmd_ff == mbcl_pkg::CMD_READ);
      cell_ctrl.read_vector    = read_vector_ff;
   end

   assign head_probe = '{active: launch_ff, found: 1'b0, vector: '0, known: 1'b0,
                         value: 1'b0, all_known: 1'b1};

   // result of the sweep
   always_ff @(posedge clock) begin
      if (capture) begin
         res_query_valid_ff  <= (cmd_ff == mbcl_pkg::CMD_NEXT) && tail_probe.found;
         res_query_vector_ff <= ((cmd_ff == mbcl_pkg::CMD_NEXT) && tail_probe.found)
                                ? mbcl_pkg::field_vec_type'(tail_probe.vector) : '0;
         res_all_resolved_ff <= tail_probe.all_known;
         res_vector_known_ff <= (cmd_ff == mbcl_pkg::CMD_READ) && tail_probe.found &&
                                tail_probe.known;
         res_vector_value_ff <= (cmd_ff == mbcl_pkg::CMD_READ) && tail_probe.found &&
                                tail_probe.known && tail_probe.value;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == mbcl_pkg::ST_DELIVER) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == mbcl_pkg::ST_DELIVER) && rsp_free) begin
         rsp_query_vector_ff <= res_query_vector_ff;
         rsp_query_valid_ff  <= res_query_valid_ff;
         rsp_all_resolved_ff <= res_all_resolved_ff;
         rsp_vector_known_ff <= res_vector_known_ff;
         rsp_vector_value_ff <= res_vector_value_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_query_vector = rsp_query_vector_ff;
   assign rsp_query_valid  = rsp_query_valid_ff;
   assign rsp_all_resolved = rsp_all_resolved_ff;
   assign rsp_vector_known = rsp_vector_known_ff;
   assign rsp_vector_value = rsp_vector_value_ff;

   `MBCL_ASSERT_NOW(a_probe_only_in_sweep,
      tail_probe.active,
      state_ff == mbcl_pkg::ST_SWEEP,
      "probe left the chain outside a sweep")
   `MBCL_ASSERT_NOW(a_query_means_unresolved,
      rsp_valid_ff && rsp_query_valid_ff,
      !rsp_all_resolved_ff,
      "query offered while everything is resolved")
   `MBCL_ASSERT_NOW(a_value_needs_known,
      rsp_valid_ff && rsp_vector_value_ff,
      rsp_vector_known_ff,
      "read value given for an unsettled vector")
   `MBCL_ASSERT_NEXT(a_answer_drops_pending,
      cell_ctrl.apply,
      !pending_valid_ff,
      "pending query kept after an answer")

endmodule

// File: hw/rtl/monotone_boolean_chain_learner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monotone_boolean_chain_learner_top
// hansel chain learner of a monotone boolean function over a row of cells
// ----------------------------------------------------------------------------
// Every word goes through the same path: an APPLY state applies a clear or an
// answer to all cells at once, then a probe walks the row of 2^DIMS cells (64)
// in query order, one cell per clock, collecting the first unknown vector, the
// read vector's bits and whether every vector is settled. The result word is
// registered once the probe leaves the row, and a new request is taken only after
// the previous one has reached its DELIVER state and its result has moved to the
// output word register. A finished result may wait under rsp_stall while the next
// request is taken.
module monotone_boolean_chain_learner_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mbcl_pkg::CMD_W-1:0]    req_command,
   input  logic                          req_answer_bit,
   input  logic [mbcl_pkg::VECTOR_W-1:0] req_read_vector,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mbcl_pkg::VECTOR_W-1:0] rsp_query_vector,
   output logic                          rsp_query_valid,
   output logic                          rsp_all_resolved,
   output logic                          rsp_vector_known,
   output logic                          rsp_vector_value
);

   mbcl_pkg::cell_ctrl_type cell_ctrl;
   mbcl_pkg::probe_type     chain_probe [mbcl_pkg::NV+1];

   mbcl_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_answer_bit   (req_answer_bit),
      .req_read_vector  (req_read_vector),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_query_vector (rsp_query_vector),
      .rsp_query_valid  (rsp_query_valid),
      .rsp_all_resolved (rsp_all_resolved),
      .rsp_vector_known (rsp_vector_known),
      .rsp_vector_value (rsp_vector_value),
      .cell_ctrl        (cell_ctrl),
      .head_probe       (chain_probe[0]),
      .tail_probe       (chain_probe[mbcl_pkg::NV])
   );

   // cells sit in query order
   for (genvar g = 0; g < mbcl_pkg::NV; g++) begin : g_cell
      mbcl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_vector (mbcl_pkg::ASK_ORDER[g]),
         .cell_ctrl   (cell_ctrl),
         .prev_probe  (chain_probe[g]),
         .next_probe  (chain_probe[g+1])
      );
   end

endmodule

// File: tb/monotone_boolean_chain_learner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monotone_boolean_chain_learner_top_tb
// drives clear, next-query, answer and read words into the hansel chain
// learner and compares every result word with a local copy of the learner
// state (typed rows: with the row's outcome); a short table of directed words
// comes first, then learning sessions against random monotone oracles and noise
// ----------------------------------------------------------------------------
module monotone_boolean_chain_learner_top_tb;

   localparam int WORD_TARGET  = 1650;
   localparam int QUIET_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 100;
   localparam int N_DIRECTED   = 22;
   localparam int REPORT_LINES = 100;

   typedef struct packed {
      logic [mbcl_pkg::VECTOR_W-1:0] query_vector;
      logic                          query_valid;
      logic                          all_resolved;
      logic                          vector_known;
      logic                          vector_value;
   } outcome_type;

   typedef struct packed {
      mbcl_pkg::cmd_type             cmd;
      logic                          answer;
      logic [mbcl_pkg::VECTOR_W-1:0] vector;
      logic                          typed;
      outcome_type                   outcome;
   } directed_row_type;

   localparam outcome_type NO_RESULT = '0;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [mbcl_pkg::CMD_W-1:0]    req_command = mbcl_pkg::CMD_CLEAR;
   logic                          req_answer_bit = 1'b0;
   logic [mbcl_pkg::VECTOR_W-1:0] req_read_vector = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [mbcl_pkg::VECTOR_W-1:0] rsp_query_vector;
   logic                          rsp_query_valid;
   logic                          rsp_all_resolved;
   logic                          rsp_vector_known;
   logic                          rsp_vector_value;

   // query order of the chains, and the learner state as the block should hold it
   int   hansel_order [mbcl_pkg::NV];
   logic shadow_known [mbcl_pkg::NV];
   logic shadow_value [mbcl_pkg::NV];
   int   shadow_pending;
   logic shadow_pending_ok;

   outcome_type                   awaited_outcomes [$];
   logic [mbcl_pkg::VECTOR_W-1:0] oracle_terms [$];
   outcome_type                   head;
   int                            words_sent;
   int                            words_taken = 0;
   int                            mismatch_count = 0;
   int                            stall_left = 0;
   int                            quiet_cycles = 0;
   logic                          sender_calm = 1'b0;
   logic                          drain_calm = 1'b0;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{mbcl_pkg::CMD_READ,   1'b0, 6'b000000, 1'b1, NO_RESULT},
      '{mbcl_pkg::CMD_READ,   1'b1, 6'b111111, 1'b1, NO_RESULT},
      '{mbcl_pkg::CMD_ANSWER, 1'b1, 6'b111111, 1'b1, NO_RESULT},
      '{mbcl_pkg::CMD_ANSWER, 1'b0, 6'b000000, 1'b1, NO_RESULT},
      '{mbcl_pkg::CMD_NEXT,   1'b1, 6'b101010, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_NEXT,   1'b0, 6'b010101, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_ANSWER, 1'b1, 6'b000000, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_ANSWER, 1'b0, 6'b111111, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_READ,   1'b0, 6'b111111, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_NEXT,   1'b0, 6'b000000, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_ANSWER, 1'b0, 6'b111111, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_READ,   1'b1, 6'b000000, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_NEXT,   1'b1, 6'b111111, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_ANSWER, 1'b1, 6'b010101, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_READ,   1'b0, 6'b101010, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_READ,   1'b1, 6'b010101, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_CLEAR,  1'b1, 6'b111111, 1'b1, NO_RESULT},
      '{mbcl_pkg::CMD_READ,   1'b1, 6'b111111, 1'b1, NO_RESULT},
      '{mbcl_pkg::CMD_ANSWER, 1'b1, 6'b000000, 1'b1, NO_RESULT},
      '{mbcl_pkg::CMD_NEXT,   1'b0, 6'b000000, 1'b0, NO_RESULT},
      '{mbcl_pkg::CMD_CLEAR,  1'b0, 6'b000000, 1'b1, NO_RESULT},
      '{mbcl_pkg::CMD_READ,   1'b0, 6'b000000, 1'b1, NO_RESULT}
   };

   monotone_boolean_chain_learner_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_answer_bit   (req_answer_bit),
      .req_read_vector  (req_read_vector),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_query_vector (rsp_query_vector),
      .rsp_query_valid  (rsp_query_valid),
      .rsp_all_resolved (rsp_all_resolved),
      .rsp_vector_known (rsp_vector_known),
      .rsp_vector_value (rsp_vector_value)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic rbit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [mbcl_pkg::VECTOR_W-1:0] rvec();
      return mbcl_pkg::VECTOR_W'($urandom_range(0, (1 << mbcl_pkg::VECTOR_W) - 1));
   endfunction

   // applies one word to the local learner state and gives the result word
   function automatic outcome_type learner_step(mbcl_pkg::cmd_type cmd, logic ans,
                                                logic [mbcl_pkg::VECTOR_W-1:0] rv);
      outcome_type res;
      logic        settled;
      logic        hit;
      int          sel;
      res = '0;
      sel = int'(rv) & (mbcl_pkg::NV - 1);
      case (cmd)
         mbcl_pkg::CMD_CLEAR: begin
            for (int v = 0; v < mbcl_pkg::NV; v++) begin
               shadow_known[v] = 1'b0;
               shadow_value[v] = 1'b0;
            end
            shadow_pending_ok = 1'b0;
         end
         mbcl_pkg::CMD_NEXT: begin
            shadow_pending_ok = 1'b0;
            for (int n = 0; n < mbcl_pkg::NV; n++) begin
               if (!shadow_pending_ok && !shadow_known[hansel_order[n]]) begin
                  shadow_pending    = hansel_order[n];
                  shadow_pending_ok = 1'b1;
                  res.query_vector  = mbcl_pkg::VECTOR_W'(hansel_order[n]);
                  res.query_valid   = 1'b1;
               end
            end
         end
         mbcl_pkg::CMD_ANSWER: begin
            if (shadow_pending_ok) begin
               for (int v = 0; v < mbcl_pkg::NV; v++) begin
                  hit = ans ? ((shadow_pending & ~v) == 0) : ((v & ~shadow_pending) == 0);
                  if (hit) begin
                     shadow_known[v] = 1'b1;
                     shadow_value[v] = ans;
                  end
               end
               shadow_pending_ok = 1'b0;
            end
         end
         default: begin
            res.vector_known = shadow_known[sel];
            res.vector_value = shadow_known[sel] & shadow_value[sel];
         end
      endcase
      settled = 1'b1;
      for (int v = 0; v < mbcl_pkg::NV; v++) begin
         if (!shadow_known[v]) begin
            settled = 1'b0;
         end
      end
      res.all_resolved = settled;
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < REPORT_LINES) begin
         $display("mismatch at result word %0d: %s", words_taken, msg);
      end
      mismatch_count++;
   endtask

   task automatic send_word(input mbcl_pkg::cmd_type cmd, input logic ans,
                            input logic [mbcl_pkg::VECTOR_W-1:0] rv, input logic typed,
                            input outcome_type typed_outcome,
                            output outcome_type predicted);
      int          gap;
      outcome_type expected;
      gap = sender_calm ? 0 : $urandom_range(0, 4);
      words_sent++;
      predicted = learner_step(cmd, ans, rv);
      expected  = typed ? typed_outcome : predicted;
      awaited_outcomes = {awaited_outcomes, expected};
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command     <= cmd;
      req_answer_bit  <= ans;
      req_read_vector <= rv;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off the sender until every result word is back
   task automatic drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_outcomes.size() != 0) @(posedge clock);
   endtask

   // result side: random stall per word, then field by field compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("result word with none expected");
         end else begin
            head = awaited_outcomes.pop_front();
            if (rsp_query_vector !== head.query_vector)
               report_mismatch($sformatf("query_vector %0h, expected %0h",
                                         rsp_query_vector, head.query_vector));
            if (rsp_query_valid !== head.query_valid)
               report_mismatch($sformatf("query_valid %0b, expected %0b",
                                         rsp_query_valid, head.query_valid));
            if (rsp_all_resolved !== head.all_resolved)
               report_mismatch($sformatf("all_resolved %0b, expected %0b",
                                         rsp_all_resolved, head.all_resolved));
            if (rsp_vector_known !== head.vector_known)
               report_mismatch($sformatf("vector_known %0b, expected %0b",
                                         rsp_vector_known, head.vector_known));
            if (rsp_vector_value !== head.vector_value)
               report_mismatch($sformatf("vector_value %0b, expected %0b",
                                         rsp_vector_value, head.vector_value));
         end
         words_taken++;
         if ($urandom_range(0, 39) == 0) begin
            drain_calm = !drain_calm;
         end
         stall_left = drain_calm ? 0 : $urandom_range(0, 4);
         rsp_stall <= (stall_left > 0);
      end else if (rsp_valid) begin
         stall_left--;
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          chain_len [mbcl_pkg::NV];
      int          chain_el [mbcl_pkg::NV][mbcl_pkg::DIMS+1];
      int          grown_len [mbcl_pkg::NV];
      int          grown_el [mbcl_pkg::NV][mbcl_pkg::DIMS+1];
      int          rank [mbcl_pkg::NV];
      int          n_chains;
      int          n_grown;
      int          slot;
      int          other;
      int          fill;
      logic        shifting;
      logic        earlier;
      logic        decided;
      logic        finished;
      logic        oracle_hit;
      outcome_type seen;
      outcome_type spare;

      // hansel chains: grow each chain by its top with the new bit set,
      // and add the remainder of the shifted copy
      n_chains       = 1;
      chain_len[0]   = 2;
      chain_el[0][0] = 0;
      chain_el[0][1] = 1;
      for (int b = 1; b < mbcl_pkg::DIMS; b++) begin
         n_grown = 0;
         for (int c = 0; c < n_chains; c++) begin
            for (int e = 0; e < chain_len[c]; e++) begin
               grown_el[n_grown][e] = chain_el[c][e];
            end
            grown_el[n_grown][chain_len[c]] = chain_el[c][chain_len[c] - 1] | (1 << b);
            grown_len[n_grown] = chain_len[c] + 1;
            n_grown++;
         end
         for (int c = 0; c < n_chains; c++) begin
            if (chain_len[c] >= 2) begin
               for (int e = 0; e < chain_len[c] - 1; e++) begin
                  grown_el[n_grown][e] = chain_el[c][e] | (1 << b);
               end
               grown_len[n_grown] = chain_len[c] - 1;
               n_grown++;
            end
         end
         chain_el  = grown_el;
         chain_len = grown_len;
         n_chains  = n_grown;
      end
      // shortest chains first, ties by their elements in turn
      for (int k = 0; k < n_chains; k++) begin
         slot     = k;
         shifting = 1'b1;
         while (shifting && slot > 0) begin
            other = rank[slot - 1];
            if (chain_len[k] != chain_len[other]) begin
               earlier = chain_len[k] < chain_len[other];
            end else begin
               earlier = 1'b0;
               decided = 1'b0;
               for (int e = 0; e < chain_len[k]; e++) begin
                  if (!decided && chain_el[k][e] != chain_el[other][e]) begin
                     earlier = chain_el[k][e] < chain_el[other][e];
                     decided = 1'b1;
                  end
               end
            end
            if (earlier) begin
               rank[slot] = other;
               slot--;
            end else begin
               shifting = 1'b0;
            end
         end
         rank[slot] = k;
      end
      fill = 0;
      for (int k = 0; k < n_chains; k++) begin
         for (int e = 0; e < chain_len[rank[k]]; e++) begin
            if (fill < mbcl_pkg::NV) begin
               hansel_order[fill] = chain_el[rank[k]][e];
               fill++;
            end
         end
      end

      for (int v = 0; v < mbcl_pkg::NV; v++) begin
         shadow_known[v] = 1'b0;
         shadow_value[v] = 1'b0;
      end
      shadow_pending    = 0;
      shadow_pending_ok = 1'b0;
      words_sent        = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].cmd, directed_rows[r].answer, directed_rows[r].vector,
                   directed_rows[r].typed, directed_rows[r].outcome, seen);
      end
      drain_pause();

      words_sent = 0;
      while (words_sent < WORD_TARGET) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            // noise: any command, any fields
            repeat ($urandom_range(5, 20)) begin
               send_word(mbcl_pkg::cmd_type'(mbcl_pkg::CMD_W'($urandom_range(0, 3))),
                         rbit(), rvec(), 1'b0, NO_RESULT, seen);
            end
         end else begin
            // learning session against a random monotone oracle
            if ($urandom_range(0, 7) == 0) begin
               drain_pause();
            end
            if ($urandom_range(0, 3) != 0) begin
               send_word(mbcl_pkg::CMD_CLEAR, rbit(), rvec(), 1'b0, NO_RESULT, seen);
            end
            oracle_terms.delete();
            case ($urandom_range(0, 9))
               0: ;
               1: oracle_terms = {oracle_terms, mbcl_pkg::VECTOR_W'(0)};
               default: begin
                  repeat ($urandom_range(1, 4)) begin
                     oracle_terms = {oracle_terms,
                                     mbcl_pkg::VECTOR_W'(rvec() & (mbcl_pkg::NV - 1))};
                  end
               end
            endcase
            finished = 1'b0;
            while (!finished && words_sent < WORD_TARGET) begin
               send_word(mbcl_pkg::CMD_NEXT, rbit(), rvec(), 1'b0, NO_RESULT, seen);
               if (!seen.query_valid) begin
                  finished = 1'b1;
               end else begin
                  case ($urandom_range(0, 15))
                     0: send_word(mbcl_pkg::CMD_READ, rbit(), rvec(), 1'b0, NO_RESULT,
                                  spare);
                     1: send_word(mbcl_pkg::CMD_NEXT, rbit(), rvec(), 1'b0, NO_RESULT,
                                  seen);
                     default: ;
                  endcase
                  if ($urandom_range(0, 49) == 0) begin
                     // session left unanswered
                     finished = 1'b1;
                  end else begin
                     oracle_hit = 1'b0;
                     foreach (oracle_terms[t]) begin
                        if ((oracle_terms[t] & ~seen.query_vector) == '0) begin
                           oracle_hit = 1'b1;
                        end
                     end
                     send_word(mbcl_pkg::CMD_ANSWER, oracle_hit, rvec(), 1'b0, NO_RESULT,
                               seen);
                     if ($urandom_range(0, 15) == 0) begin
                        send_word(mbcl_pkg::CMD_ANSWER, rbit(), rvec(), 1'b0, NO_RESULT,
                                  seen);
                     end
                  end
               end
            end
            if ($urandom_range(0, 2) == 0) begin
               send_word(mbcl_pkg::CMD_ANSWER, rbit(), rvec(), 1'b0, NO_RESULT, seen);
            end
            repeat ($urandom_range(1, 4)) begin
               send_word(mbcl_pkg::CMD_READ, rbit(), rvec(), 1'b0, NO_RESULT, seen);
            end
         end
      end

      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
